[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the set cover checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held, generic message.
`define GSC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed in %m");

// Clocked assertion, disabled while reset is held, caller message.
`define GSC_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

[rtl/gsc_pkg.sv]
// ----------------------------------------------------------------------------
// Greedy set cover package
// Widths, limits, codes and the popcount helper shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsc_pkg;

  localparam int unsigned MASK_W       = 64;
  localparam int unsigned EC_W         = 7;
  localparam int unsigned SC_W         = 6;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned PC_W         = 7;
  localparam int unsigned PROD_W       = 6;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned MAX_SUBSETS  = 32;
  localparam int unsigned RESULT_CAP   = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEMENT_COUNT = 2'd0,
    CFG_SUBSET_COUNT  = 2'd1,
    CFG_UNIVERSE_MASK = 2'd2
  } cfg_idx_e;

  // Adder tree, six levels, each level over independent pairs.
  function automatic logic [PC_W-1:0] popcount64(input logic [MASK_W-1:0] v);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) begin
      l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    end
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

endpackage

`default_nettype wire

[rtl/gsc_in_if.sv]
// ----------------------------------------------------------------------------
// Set cover input channel
// Valid/ready channel carrying load and solve words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gsc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic [gsc_pkg::IDX_W-1:0]            subset_index;
  logic [gsc_pkg::MASK_W-1:0]           subset_mask;

  modport source (
    output valid, opcode, subset_index, subset_mask,
    input  ready
  );
  modport sink (
    input  valid, opcode, subset_index, subset_mask,
    output ready
  );
endinterface

`default_nettype wire

[rtl/gsc_out_if.sv]
// ----------------------------------------------------------------------------
// Set cover result channel
// Valid/ready channel carrying one chosen subset per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gsc_out_if;
  logic                      valid;
  logic                      ready;
  logic [gsc_pkg::IDX_W-1:0] chosen_index;
  logic                      last;
  logic                      empty_res;

  modport source (
    output valid, chosen_index, last, empty_res,
    input  ready
  );
  modport sink (
    input  valid, chosen_index, last, empty_res,
    output ready
  );
endinterface

`default_nettype wire

[rtl/gsc_store.sv]
// ----------------------------------------------------------------------------
// Subset store
// Single write port, single registered read port subset memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsc_store #(
  parameter int unsigned DEPTH = gsc_pkg::MAX_SUBSETS,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [gsc_pkg::MASK_W-1:0]  wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output      logic [gsc_pkg::MASK_W-1:0]  rdata_o
);

  logic [gsc_pkg::MASK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/greedy_set_cover.sv]
// Load word: the input stays ready after a load word is accepted.
// Solve word: each greedy round scans the subset store one entry per cycle
// through the shared popcount/compare pipeline; up to 32 rounds per solve.
// Input is not ready from solve accept until the final result is registered.
// Reset restores control and default configuration; store contents undefined.
// ----------------------------------------------------------------------------
// Greedy set cover engine
// Stores subset masks and emits greedy cover choices one round at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_set_cover #(
  parameter int unsigned MAX_SUBSETS = gsc_pkg::MAX_SUBSETS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [gsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [gsc_pkg::MASK_W-1:0]     cfg_data_i,
  gsc_in_if.sink                              in_i,
  gsc_out_if.source                           out_o
);

  localparam int unsigned AW  = (MAX_SUBSETS > 1) ? $clog2(MAX_SUBSETS) : 1;
  localparam int unsigned SCW = (AW + 1 > 6) ? AW + 1 : 6;
  localparam int unsigned MW  = gsc_pkg::MASK_W;
  localparam int unsigned PW  = gsc_pkg::PC_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_PICK  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [gsc_pkg::EC_W-1:0] elem_cnt_q;
  logic [gsc_pkg::SC_W-1:0] sub_cnt_q;
  logic [MW-1:0]            univ_q;

  logic [MW-1:0]   covered_q, covered_d;
  logic [MW-1:0]   emask_q, emask_d;
  logic [MW-1:0]   target_q, target_d;
  logic [SCW-1:0]  limit_q, limit_d;
  logic [gsc_pkg::PROD_W-1:0] produced_q, produced_d;
  logic            pend_v_q, pend_v_d;
  logic [SCW-1:0]  pend_idx_q, pend_idx_d;
  logic [SCW-1:0]  issue_q, issue_d;
  logic            v1_q, v1_d;
  logic [SCW-1:0]  idx1_q, idx1_d;
  logic            v2_q, v2_d;
  logic [SCW-1:0]  idx2_q, idx2_d;
  logic [PW-1:0]   pc2_q, pc2_d;
  logic [MW-1:0]   data2_q, data2_d;
  logic            found_q, found_d;
  logic [PW-1:0]   best_cnt_q, best_cnt_d;
  logic [SCW-1:0]  best_idx_q, best_idx_d;
  logic [MW-1:0]   best_mask_q, best_mask_d;
  logic            out_v_q, out_v_d;
  logic [gsc_pkg::IDX_W-1:0] out_idx_q, out_idx_d;
  logic            out_last_q, out_last_d;
  logic            out_empty_q, out_empty_d;

  logic            in_fire;
  logic            out_free;
  logic            rd_en;
  logic            more;
  logic            need_emit;
  logic [SCW-1:0]  slot_ext;
  logic            st_we;
  logic [MW-1:0]   rd_data;
  logic [gsc_pkg::EC_W-1:0] ec_sat;
  logic [MW-1:0]   emask_new;
  logic [SCW-1:0]  sc_ext;

  assign in_i.ready         = (state_q == ST_IDLE);
  assign in_fire            = in_i.valid && in_i.ready;
  assign out_free           = !out_v_q || out_o.ready;
  assign out_o.valid        = out_v_q;
  assign out_o.chosen_index = out_idx_q;
  assign out_o.last         = out_last_q;
  assign out_o.empty_res    = out_empty_q;

  assign slot_ext = SCW'(in_i.subset_index);
  assign st_we    = in_fire && (in_i.opcode == gsc_pkg::OP_LOAD)
                    && (slot_ext < SCW'(MAX_SUBSETS));
  assign rd_en    = (state_q == ST_SCAN) && (issue_q < limit_q);

  // Saturated in-use element mask and subset limit for a new solve.
  assign ec_sat    = (elem_cnt_q > gsc_pkg::EC_W'(gsc_pkg::MAX_ELEMENTS))
                     ? gsc_pkg::EC_W'(gsc_pkg::MAX_ELEMENTS) : elem_cnt_q;
  assign emask_new = (ec_sat >= gsc_pkg::EC_W'(MW)) ? {MW{1'b1}}
                     : ((MW'(1) << ec_sat) - MW'(1));
  assign sc_ext    = SCW'(sub_cnt_q);

  assign more      = ((covered_q & emask_q) != target_q)
                     && (produced_q < gsc_pkg::PROD_W'(gsc_pkg::RESULT_CAP));
  assign need_emit = pend_v_q || !found_q;

  gsc_store #(
    .DEPTH (MAX_SUBSETS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (slot_ext[AW-1:0]),
    .wdata_i (in_i.subset_mask),
    .re_i    (rd_en),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    covered_d   = covered_q;
    emask_d     = emask_q;
    target_d    = target_q;
    limit_d     = limit_q;
    produced_d  = produced_q;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    issue_d     = issue_q;
    v1_d        = 1'b0;
    idx1_d      = idx1_q;
    v2_d        = 1'b0;
    idx2_d      = idx2_q;
    pc2_d       = pc2_q;
    data2_d     = data2_q;
    found_d     = found_q;
    best_cnt_d  = best_cnt_q;
    best_idx_d  = best_idx_q;
    best_mask_d = best_mask_q;
    out_v_d     = out_v_q && !out_o.ready;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.opcode == gsc_pkg::OP_SOLVE)) begin
          covered_d  = '0;
          emask_d    = emask_new;
          target_d   = univ_q & emask_new;
          limit_d    = (sc_ext > SCW'(MAX_SUBSETS)) ? SCW'(MAX_SUBSETS) : sc_ext;
          produced_d = '0;
          pend_v_d   = 1'b0;
          state_d    = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (more) begin
          found_d    = 1'b0;
          best_cnt_d = '0;
          issue_d    = '0;
          state_d    = ST_SCAN;
        end else if (out_free) begin
          // Run is over: flush the held pick as final, or flag an empty run.
          out_v_d     = 1'b1;
          out_idx_d   = pend_v_q ? pend_idx_q[gsc_pkg::IDX_W-1:0] : '0;
          out_last_d  = 1'b1;
          out_empty_d = !pend_v_q;
          state_d     = ST_IDLE;
        end
      end

      ST_SCAN: begin
        v1_d    = rd_en;
        idx1_d  = issue_q;
        if (rd_en) begin
          issue_d = issue_q + SCW'(1);
        end
        v2_d    = v1_q;
        idx2_d  = idx1_q;
        pc2_d   = gsc_pkg::popcount64(rd_data & ~covered_q & emask_q);
        data2_d = rd_data;
        // Strictly larger only, so the lowest index keeps a tie.
        if (v2_q && (pc2_q > best_cnt_q)) begin
          found_d     = 1'b1;
          best_cnt_d  = pc2_q;
          best_idx_d  = idx2_q;
          best_mask_d = data2_q;
        end
        if (!rd_en && !v1_q && !v2_q) begin
          state_d = ST_PICK;
        end
      end

      ST_PICK: begin
        if (!need_emit || out_free) begin
          if (found_q) begin
            covered_d  = covered_q | (best_mask_q & emask_q);
            produced_d = produced_q + gsc_pkg::PROD_W'(1);
            if (pend_v_q) begin
              out_v_d     = 1'b1;
              out_idx_d   = pend_idx_q[gsc_pkg::IDX_W-1:0];
              out_last_d  = 1'b0;
              out_empty_d = 1'b0;
            end
            // Hold the new pick until the next round tells whether it is last.
            pend_idx_d = best_idx_q;
            pend_v_d   = 1'b1;
            state_d    = ST_CHECK;
          end else begin
            out_v_d     = 1'b1;
            out_idx_d   = pend_v_q ? pend_idx_q[gsc_pkg::IDX_W-1:0] : '0;
            out_last_d  = 1'b1;
            out_empty_d = !pend_v_q;
            state_d     = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      elem_cnt_q <= gsc_pkg::EC_W'(gsc_pkg::MAX_ELEMENTS);
      sub_cnt_q  <= '0;
      univ_q     <= {MW{1'b1}};
      covered_q  <= '0;
      produced_q <= '0;
      pend_v_q   <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      found_q    <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      covered_q  <= covered_d;
      produced_q <= produced_d;
      pend_v_q   <= pend_v_d;
      v1_q       <= v1_d;
      v2_q       <= v2_d;
      found_q    <= found_d;
      out_v_q    <= out_v_d;
      if (cfg_we_i) begin
        unique case (gsc_pkg::cfg_idx_e'(cfg_idx_i))
          gsc_pkg::CFG_ELEMENT_COUNT: elem_cnt_q <= cfg_data_i[gsc_pkg::EC_W-1:0];
          gsc_pkg::CFG_SUBSET_COUNT:  sub_cnt_q  <= cfg_data_i[gsc_pkg::SC_W-1:0];
          gsc_pkg::CFG_UNIVERSE_MASK: univ_q     <= cfg_data_i;
          default: begin
            // drop writes to unmapped indexes
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    emask_q     <= emask_d;
    target_q    <= target_d;
    limit_q     <= limit_d;
    pend_idx_q  <= pend_idx_d;
    issue_q     <= issue_d;
    idx1_q      <= idx1_d;
    idx2_q      <= idx2_d;
    pc2_q       <= pc2_d;
    data2_q     <= data2_d;
    best_cnt_q  <= best_cnt_d;
    best_idx_q  <= best_idx_d;
    best_mask_q <= best_mask_d;
    out_idx_q   <= out_idx_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

endmodule

`default_nettype wire

[rtl/gsc_checker.sv]
// ----------------------------------------------------------------------------
// Set cover port checker
// Port-level assertions on the set cover engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gsc_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      in_opcode_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [gsc_pkg::IDX_W-1:0] out_chosen_index_i,
  input wire logic                      out_last_i,
  input wire logic                      out_empty_res_i
);

  // A stalled result word holds.
  `GSC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_chosen_index_i) && $stable(out_last_i) && $stable(out_empty_res_i))

  // An empty run is a single final word with index zero.
  `GSC_ASSERT_MSG(a_empty_final, clk_i, rst_ni, out_valid_i && out_empty_res_i |-> out_last_i && (out_chosen_index_i == '0), "empty result not final or index nonzero")

  // A solve word blocks the input while the run is in progress.
  `GSC_ASSERT_MSG(a_solve_busy, clk_i, rst_ni, in_valid_i && in_ready_i && (in_opcode_i == gsc_pkg::OP_SOLVE) |=> !in_ready_i, "input ready right after solve")

  // A load word leaves the input ready in the next cycle.
  `GSC_ASSERT(a_load_fast, clk_i, rst_ni, in_valid_i && in_ready_i && (in_opcode_i == gsc_pkg::OP_LOAD) |=> in_ready_i)

endmodule

bind greedy_set_cover gsc_checker u_gsc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_opcode_i        (in_i.opcode),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_chosen_index_i (out_o.chosen_index),
  .out_last_i         (out_o.last),
  .out_empty_res_i    (out_o.empty_res)
);

`default_nettype wire
